// ===== hw/rtl/overwrite_ring_pingpong_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// overwrite_ring_pingpong_buffer_defines
// Assertion macros shared by the checker of the ring buffer.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_PINGPONG_BUFFER_DEFINES_SVH
`define OVERWRITE_RING_PINGPONG_BUFFER_DEFINES_SVH

// same-cycle implication
`define ORPB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ORPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/orpb_pkg.sv =====
// ----------------------------------------------------------------------------
// orpb_pkg
// Opcodes and controller/datapath interface types of the ring buffer.
// ----------------------------------------------------------------------------
package orpb_pkg;

	localparam logic OP_ENQ   = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic enq;
		logic drain_start;
		logic empty_drain;
		logic read_step;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
		logic out_valid;
	} status_t;

endpackage

// ===== hw/rtl/orpb_datapath.sv =====
// ----------------------------------------------------------------------------
// orpb_datapath
// Two-bank word memory, fill pointer and wrap flag, drain read pointer,
// and the output register.
// ----------------------------------------------------------------------------
module orpb_datapath #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  orpb_pkg::cmd_t   cmd,
	output orpb_pkg::status_t status,
	input  logic             out_stall,
	input  logic [31:0]      entry_word,
	output logic             out_valid,
	output logic [31:0]      out_word,
	output logic             is_last,
	output logic             was_empty,
	output logic             overflowed
);
	import orpb_pkg::*;

	localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW        = $clog2(DEPTH + 1);
	localparam int MEM_DEPTH = 2 * (2 ** IW);

	logic [WORD_BITS-1:0] mem [MEM_DEPTH];

	logic          fill_q;
	logic [CW-1:0] widx_q;
	logic          wrap_q;
	logic          rd_bank_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic          wrapped_q;

	logic [WORD_BITS-1:0] rd_q;
	logic                 out_valid_q;
	logic                 last_q;
	logic                 empty_q;
	logic                 ovf_q;

	logic          full;
	logic [IW-1:0] wr_pos;
	logic [IW-1:0] start_pos;

	assign full      = (widx_q == CW'(DEPTH));
	assign wr_pos    = full ? '0 : widx_q[IW-1:0];
	assign start_pos = (wrap_q && !full) ? widx_q[IW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			mem[{fill_q, wr_pos}] <= WORD_BITS'(entry_word);
		end
		if (cmd.read_step) begin
			rd_q <= mem[{rd_bank_q, pos_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 1'b0;
			widx_q    <= '0;
			wrap_q    <= 1'b0;
			rd_bank_q <= 1'b0;
			pos_q     <= '0;
			cnt_q     <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (cmd.enq) begin
				if (full) begin
					widx_q <= CW'(1);
					wrap_q <= 1'b1;
				end else begin
					widx_q <= widx_q + 1'b1;
				end
			end
			if (cmd.drain_start) begin
				rd_bank_q <= fill_q;
				fill_q    <= ~fill_q;
				pos_q     <= start_pos;
				cnt_q     <= wrap_q ? CW'(DEPTH) : widx_q;
				wrapped_q <= wrap_q;
				widx_q    <= '0;
				wrap_q    <= 1'b0;
			end
			if (cmd.read_step) begin
				pos_q <= (pos_q == IW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			empty_q     <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			priority if (cmd.read_step) begin
				out_valid_q <= 1'b1;
				last_q      <= (cnt_q == CW'(1));
				empty_q     <= 1'b0;
				ovf_q       <= wrapped_q;
			end else if (cmd.empty_drain) begin
				out_valid_q <= 1'b1;
				last_q      <= 1'b1;
				empty_q     <= 1'b1;
				ovf_q       <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.empty     = (widx_q == '0) && !wrap_q;
	assign status.last      = (cnt_q == CW'(1));
	assign status.out_valid = out_valid_q;

	assign out_valid  = out_valid_q;
	assign out_word   = empty_q ? '0 : 32'(rd_q);
	assign is_last    = last_q;
	assign was_empty  = empty_q;
	assign overflowed = ovf_q;

endmodule

// ===== hw/rtl/orpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// orpb_ctrl
// Input handshake and drain sequencer of the ring buffer.
// ----------------------------------------------------------------------------
module orpb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic              out_stall,
	input  orpb_pkg::status_t status,
	output orpb_pkg::cmd_t    cmd
);
	import orpb_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;
	logic slot_free;

	assign slot_free = !status.out_valid || !out_stall;
	assign in_stall  = (state_q == ST_DRAIN) || ((opcode == OP_DRAIN) && !slot_free);
	assign accept    = in_valid && !in_stall;

	assign cmd.enq         = accept && (opcode == OP_ENQ);
	assign cmd.drain_start = accept && (opcode == OP_DRAIN) && !status.empty;
	assign cmd.empty_drain = accept && (opcode == OP_DRAIN) && status.empty;
	assign cmd.read_step   = (state_q == ST_DRAIN) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.drain_start) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cmd.read_step && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/overwrite_ring_pingpong_buffer.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_pingpong_buffer
// Double-buffered ring buffer that overwrites its oldest entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): opcode 0 enqueues entry_word into the
// bank being filled, one beat per cycle, no result. When the bank is full the
// next enqueue wraps to entry zero and marks the bank overflowed.
// opcode 1 drains: the banks swap and the old bank is sent oldest first on the
// output channel (out_valid/out_stall), one beat per cycle, is_last on the
// final beat and overflowed on every beat if the bank wrapped. A drain of an
// empty buffer sends one beat with was_empty and is_last set.
// An empty drain shows its beat in the output register right after the drain
// beat's edge; a non-empty drain first enters the drain state, then reads the
// memory into the output register to show its first beat.
// The input is held off while the drain reads out the stored entries (DEPTH
// if wrapped) and while the receiver stalls. A drain beat is also held off
// while a beat waits stalled in the output register. Enqueues run at one per
// cycle outside a drain, also while a result waits in the output register.
// Reset clears the fill pointer, wrap flag, bank select and output valid; the
// memory is not cleared. A stalled receiver holds the current beat and halts
// the drain sequence.
module overwrite_ring_pingpong_buffer #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] entry_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_word,
	output logic        is_last,
	output logic        was_empty,
	output logic        overflowed
);
	import orpb_pkg::*;

	cmd_t    cmd;
	status_t status;

	orpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	orpb_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.out_stall  (out_stall),
		.entry_word (entry_word),
		.out_valid  (out_valid),
		.out_word   (out_word),
		.is_last    (is_last),
		.was_empty  (was_empty),
		.overflowed (overflowed)
	);

endmodule

// ===== hw/rtl/orpb_checker.sv =====
// ----------------------------------------------------------------------------
// orpb_checker
// Port-level checks of the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "overwrite_ring_pingpong_buffer_defines.svh"

module orpb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_word,
	input logic        is_last,
	input logic        was_empty,
	input logic        overflowed
);

	`ORPB_ASSERT_NEXT(a_hold_beat, out_valid && out_stall,
		out_valid && $stable(out_word) && $stable(is_last) && $stable(was_empty)
		&& $stable(overflowed), "stalled output beat changed")

	`ORPB_ASSERT_NOW(a_empty_beat, out_valid && was_empty,
		is_last && !overflowed && (out_word == 32'd0), "empty drain beat malformed")

	`ORPB_ASSERT_NOW(a_hold_input, out_valid && !is_last, in_stall, "input taken during a drain")

	`ORPB_ASSERT_NEXT(a_drain_cont, out_valid && !out_stall && !is_last, out_valid,
		"drain sequence broke off")

endmodule

bind overwrite_ring_pingpong_buffer orpb_checker u_orpb_checker (.*);
